// ===== hw/rtl/pic_scanline_rle_decoder_defines.svh =====
// ----------------------------------------------------------------------------
// Scanline RLE decoder assertion macros
// Shared property shorthands for the decoder's checker; they assume signals
// named clk and rst_n in the scope where they are used.
// ----------------------------------------------------------------------------
`ifndef PIC_SCANLINE_RLE_DECODER_DEFINES_SVH
`define PIC_SCANLINE_RLE_DECODER_DEFINES_SVH

// same-cycle implication, disabled while in reset
`define PSRD_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("psrd check failed in same cycle");

// next-cycle implication, disabled while in reset
`define PSRD_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("psrd check failed in next cycle");

`endif

// ===== hw/rtl/psrd_pkg.sv =====
// ----------------------------------------------------------------------------
// Scanline RLE decoder package
// Parse phase codes, register indexes, coding constants and the result type.
// ----------------------------------------------------------------------------
package psrd_pkg;

  // run length and position sum widths
  localparam int LEN_W = 16;
  localparam int SUM_W = LEN_W + 1;

  // parse phases
  localparam logic [1:0] PH_COUNT = 2'd0;
  localparam logic [1:0] PH_HIGH  = 2'd1;
  localparam logic [1:0] PH_LOW   = 2'd2;
  localparam logic [1:0] PH_COMP  = 2'd3;

  // channel codings
  localparam logic [1:0] ENC_RAW   = 2'd0;
  localparam logic [1:0] ENC_PURE  = 2'd1;
  localparam logic [1:0] ENC_MIXED = 2'd2;
  localparam logic [1:0] ENC_RSVD  = 2'd3;

  // configuration register indexes
  localparam logic [2:0] CFG_LINE_WIDTH      = 3'd0;
  localparam logic [2:0] CFG_CHANNEL_COUNT   = 3'd1;
  localparam logic [2:0] CFG_FIRST_ENCODING  = 3'd2;
  localparam logic [2:0] CFG_FIRST_MASK      = 3'd3;
  localparam logic [2:0] CFG_SECOND_ENCODING = 3'd4;
  localparam logic [2:0] CFG_SECOND_MASK     = 3'd5;

  // mixed-run count byte codes
  localparam logic [7:0] CNT_LONG    = 8'd128;
  localparam logic [7:0] REPEAT_BIAS = 8'd127;
  localparam logic [3:0] MASK_ALL    = 4'hF;

  // one decoded run
  typedef struct packed {
    logic [15:0] start_x;
    logic [15:0] run_length;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic [7:0]  alpha;
    logic [3:0]  write_mask;
    logic        channel_index;
    logic        line_done;
    logic        status;
  } res_t;

endpackage

// ===== hw/rtl/pic_scanline_rle_decoder.sv =====
// ----------------------------------------------------------------------------
// Picture scanline run-length decoder
// Decodes one compressed byte per beat into runs of pixel components.
// ----------------------------------------------------------------------------
// Takes one byte of the compressed stream per cycle and emits at most one run
// per byte. Each byte is held in the input register until the result slot is
// free and then leaves its result in the output register, from which its run
// is presented. Throughput is one byte per cycle while out_stall is low; the
// whole parse state (phase, counts, position, channel) is updated in the cycle
// the byte is processed. Configuration writes are always taken (cfg_ready
// stays high) and apply from the next byte; write them only when the decoder
// is idle.
module pic_scanline_rle_decoder #(
  parameter int POSITION_BITS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  // byte input
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_data_byte,
  // run output
  output logic        out_valid,
  input  logic        out_stall,
  output logic [15:0] out_start_x,
  output logic [15:0] out_run_length,
  output logic [7:0]  out_red,
  output logic [7:0]  out_green,
  output logic [7:0]  out_blue,
  output logic [7:0]  out_alpha,
  output logic [3:0]  out_write_mask,
  output logic        out_channel_index,
  output logic        out_line_done,
  output logic        out_status,
  // configuration writes
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  localparam int P = POSITION_BITS;
  localparam int SUM_W_L = psrd_pkg::SUM_W;

  // configuration registers
  logic [15:0] line_width_r;
  logic [1:0]  chan_count_r;
  logic [1:0]  first_enc_r;
  logic [3:0]  first_mask_r;
  logic [1:0]  second_enc_r;
  logic [3:0]  second_mask_r;

  // input register
  logic        in_valid_r;
  logic [7:0]  in_byte_r;

  // parse state
  logic [1:0]  phase_r, phase_nxt;
  logic [1:0]  comp_idx_r, comp_idx_nxt;
  logic [15:0] pending_r, pending_nxt;
  logic [7:0]  literal_r, literal_nxt;
  logic [P-1:0] pos_r, pos_nxt;
  logic        chan_r, chan_nxt;
  logic        repeat_r, repeat_nxt;
  logic [7:0]  held_r [4];
  logic [7:0]  held_nxt [4];

  // output register
  logic           out_valid_r;
  psrd_pkg::res_t res_r, res_nxt;

  // datapath
  logic        fire;
  logic        emit;
  logic [P-1:0] width_eff;
  logic [P-1:0] rem;
  logic        two_chan;
  logic        chan_last;
  logic [1:0]  enc;
  logic [3:0]  mask;
  logic [2:0]  mask_pop;
  logic        do_comp;
  logic [1:0]  ci_in;
  logic [1:0]  ci_inc;
  logic        rep_in;
  logic [7:0]  lit_in;
  logic [7:0]  lit_dec;
  logic [15:0] count;
  logic [15:0] run_len;
  logic [SUM_W_L-1:0] pos_ext;
  logic [SUM_W_L-1:0] ovr_sum;
  logic [SUM_W_L-1:0] run_sum;
  logic        ovr;
  logic        chan_end;
  logic [1:0]  k_green;
  logic [1:0]  k_blue;
  logic [1:0]  k_alpha;

  assign cfg_ready = 1'b1;

  // configuration write port
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      line_width_r  <= 16'd1;
      chan_count_r  <= 2'd1;
      first_enc_r   <= psrd_pkg::ENC_RAW;
      first_mask_r  <= 4'd14;
      second_enc_r  <= psrd_pkg::ENC_RAW;
      second_mask_r <= 4'd1;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        psrd_pkg::CFG_LINE_WIDTH:      line_width_r  <= cfg_data;
        psrd_pkg::CFG_CHANNEL_COUNT:   chan_count_r  <= cfg_data[1:0];
        psrd_pkg::CFG_FIRST_ENCODING:  first_enc_r   <= cfg_data[1:0];
        psrd_pkg::CFG_FIRST_MASK:      first_mask_r  <= cfg_data[3:0];
        psrd_pkg::CFG_SECOND_ENCODING: second_enc_r  <= cfg_data[1:0];
        psrd_pkg::CFG_SECOND_MASK:     second_mask_r <= cfg_data[3:0];
        default: ;
      endcase
    end
  end

  // effective settings for the active channel
  always_comb begin
    width_eff = (line_width_r[P-1:0] == '0) ? P'(1) : line_width_r[P-1:0];
    two_chan  = chan_count_r[1];
    chan_last = chan_r | ~two_chan;
    enc       = chan_r ? second_enc_r : first_enc_r;
    if (enc == psrd_pkg::ENC_RSVD) begin
      enc = psrd_pkg::ENC_RAW;
    end
    mask = chan_r ? second_mask_r : first_mask_r;
    if (mask == 4'h0) begin
      mask = psrd_pkg::MASK_ALL;
    end
    mask_pop = 3'(mask[3]) + 3'(mask[2]) + 3'(mask[1]) + 3'(mask[0]);
    rem      = (pos_r < width_eff) ? (width_eff - pos_r) : '0;
    pos_ext  = SUM_W_L'(pos_r);
  end

  // handshake: a byte is processed when the result slot is free
  assign fire     = in_valid_r && (!out_valid_r || !out_stall);
  assign in_stall = in_valid_r && !fire;

  // byte parse and run assembly
  always_comb begin
    phase_nxt    = phase_r;
    comp_idx_nxt = comp_idx_r;
    pending_nxt  = pending_r;
    literal_nxt  = literal_r;
    pos_nxt      = pos_r;
    chan_nxt     = chan_r;
    repeat_nxt   = repeat_r;
    held_nxt     = held_r;
    res_nxt      = res_r;
    emit         = 1'b0;
    count        = '0;
    ovr_sum      = '0;
    ovr          = 1'b0;
    run_len      = '0;
    run_sum      = '0;
    chan_end     = 1'b0;
    lit_dec      = '0;
    k_green      = '0;
    k_blue       = '0;
    k_alpha      = '0;

    // raw coding reads its count byte as the first component byte
    do_comp = fire && ((phase_r == psrd_pkg::PH_COMP) ||
                       ((phase_r == psrd_pkg::PH_COUNT) && (enc == psrd_pkg::ENC_RAW)));
    ci_in   = (phase_r == psrd_pkg::PH_COUNT) ? 2'd0 : comp_idx_r;
    rep_in  = (phase_r == psrd_pkg::PH_COUNT) ? 1'b0 : repeat_r;
    lit_in  = (phase_r == psrd_pkg::PH_COUNT) ? 8'd1 : literal_r;
    ci_inc  = ci_in + 2'd1;

    // count and long-count bytes
    if (fire && !do_comp) begin
      case (phase_r)
        psrd_pkg::PH_COUNT: begin
          if (enc == psrd_pkg::ENC_PURE) begin
            count = (16'(in_byte_r) > 16'(rem)) ? 16'(rem) : 16'(in_byte_r);
          end else if (in_byte_r > psrd_pkg::CNT_LONG) begin
            count = 16'(in_byte_r - psrd_pkg::REPEAT_BIAS);
          end else begin
            count = 16'(in_byte_r) + 16'd1;
          end
        end
        psrd_pkg::PH_LOW: count = {pending_r[15:8], in_byte_r};
        default: count = '0;
      endcase

      ovr_sum = pos_ext + SUM_W_L'(count);
      ovr     = (ovr_sum > SUM_W_L'(width_eff)) && (enc != psrd_pkg::ENC_PURE ||
                                                    phase_r != psrd_pkg::PH_COUNT);

      case (phase_r)
        psrd_pkg::PH_COUNT: begin
          if (enc == psrd_pkg::ENC_MIXED && in_byte_r == psrd_pkg::CNT_LONG) begin
            // long count follows, nothing to check yet
            phase_nxt = psrd_pkg::PH_HIGH;
            ovr       = 1'b0;
          end else if (!ovr) begin
            if (enc == psrd_pkg::ENC_PURE || in_byte_r > psrd_pkg::CNT_LONG) begin
              pending_nxt = count;
              repeat_nxt  = 1'b1;
            end else begin
              literal_nxt = count[7:0];
              repeat_nxt  = 1'b0;
            end
            comp_idx_nxt = 2'd0;
            phase_nxt    = psrd_pkg::PH_COMP;
          end
        end
        psrd_pkg::PH_HIGH: begin
          pending_nxt = {in_byte_r, 8'h00};
          phase_nxt   = psrd_pkg::PH_LOW;
          ovr         = 1'b0;
        end
        psrd_pkg::PH_LOW: begin
          if (!ovr) begin
            pending_nxt  = count;
            repeat_nxt   = 1'b1;
            comp_idx_nxt = 2'd0;
            phase_nxt    = psrd_pkg::PH_COMP;
          end
        end
        default: ovr = 1'b0;
      endcase

      // overrun: report and restart the line
      if (ovr) begin
        emit                  = 1'b1;
        res_nxt.start_x       = 16'(pos_r);
        res_nxt.run_length    = count;
        res_nxt.red           = '0;
        res_nxt.green         = '0;
        res_nxt.blue          = '0;
        res_nxt.alpha         = '0;
        res_nxt.write_mask    = '0;
        res_nxt.channel_index = chan_r;
        res_nxt.line_done     = 1'b0;
        res_nxt.status        = 1'b1;
        phase_nxt    = psrd_pkg::PH_COUNT;
        comp_idx_nxt = '0;
        pending_nxt  = '0;
        literal_nxt  = '0;
        pos_nxt      = '0;
        chan_nxt     = 1'b0;
        repeat_nxt   = 1'b0;
      end
    end

    // component bytes
    if (do_comp) begin
      held_nxt[ci_in] = in_byte_r;
      phase_nxt       = psrd_pkg::PH_COMP;
      repeat_nxt      = rep_in;
      literal_nxt     = lit_in;
      comp_idx_nxt    = ci_inc;
      if (ci_inc == 2'd0 || {1'b0, ci_inc} >= mask_pop) begin
        comp_idx_nxt = 2'd0;
        if (rep_in) begin
          run_len   = pending_r;
          phase_nxt = psrd_pkg::PH_COUNT;
        end else begin
          run_len     = 16'd1;
          lit_dec     = lit_in - 8'd1;
          literal_nxt = lit_dec;
          phase_nxt   = (lit_dec != 8'd0) ? psrd_pkg::PH_COMP : psrd_pkg::PH_COUNT;
        end
        run_sum  = pos_ext + SUM_W_L'(run_len);
        chan_end = run_sum >= SUM_W_L'(width_eff);
        pos_nxt  = run_sum[P-1:0];
        if (chan_end) begin
          chan_nxt     = ~chan_last;
          pos_nxt      = '0;
          phase_nxt    = psrd_pkg::PH_COUNT;
          literal_nxt  = '0;
          comp_idx_nxt = '0;
        end

        // place held bytes by mask, red first
        k_green = {1'b0, mask[3]};
        k_blue  = 2'(mask[3]) + 2'(mask[2]);
        k_alpha = 2'(mask[3]) + 2'(mask[2]) + 2'(mask[1]);
        if (run_len != 16'd0) begin
          emit                  = 1'b1;
          res_nxt.start_x       = 16'(pos_r);
          res_nxt.run_length    = run_len;
          res_nxt.red           = mask[3] ? held_nxt[2'd0] : 8'd0;
          res_nxt.green         = mask[2] ? held_nxt[k_green] : 8'd0;
          res_nxt.blue          = mask[1] ? held_nxt[k_blue] : 8'd0;
          res_nxt.alpha         = mask[0] ? held_nxt[k_alpha] : 8'd0;
          res_nxt.write_mask    = mask;
          res_nxt.channel_index = chan_r;
          res_nxt.line_done     = chan_end && chan_last;
          res_nxt.status        = 1'b0;
        end
      end
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      phase_r     <= psrd_pkg::PH_COUNT;
      comp_idx_r  <= '0;
      pending_r   <= '0;
      literal_r   <= '0;
      pos_r       <= '0;
      chan_r      <= 1'b0;
      repeat_r    <= 1'b0;
    end else begin
      if (!in_stall) begin
        in_valid_r <= in_valid;
      end
      if (fire && emit) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
      phase_r    <= phase_nxt;
      comp_idx_r <= comp_idx_nxt;
      pending_r  <= pending_nxt;
      literal_r  <= literal_nxt;
      pos_r      <= pos_nxt;
      chan_r     <= chan_nxt;
      repeat_r   <= repeat_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      in_byte_r <= in_data_byte;
    end
    if (fire && emit) begin
      res_r <= res_nxt;
    end
    held_r <= held_nxt;
  end

  assign out_valid         = out_valid_r;
  assign out_start_x       = res_r.start_x;
  assign out_run_length    = res_r.run_length;
  assign out_red           = res_r.red;
  assign out_green         = res_r.green;
  assign out_blue          = res_r.blue;
  assign out_alpha         = res_r.alpha;
  assign out_write_mask    = res_r.write_mask;
  assign out_channel_index = res_r.channel_index;
  assign out_line_done     = res_r.line_done;
  assign out_status        = res_r.status;

endmodule

// ===== hw/rtl/psrd_checker.sv =====
// ----------------------------------------------------------------------------
// Scanline RLE decoder port checker
// Watches the decoder's result port and is bound onto the top level.
// ----------------------------------------------------------------------------
`include "pic_scanline_rle_decoder_defines.svh"

module psrd_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_stall,
  input logic [15:0] out_start_x,
  input logic [15:0] out_run_length,
  input logic [7:0]  out_red,
  input logic [7:0]  out_green,
  input logic [7:0]  out_blue,
  input logic [7:0]  out_alpha,
  input logic [3:0]  out_write_mask,
  input logic        out_channel_index,
  input logic        out_line_done,
  input logic        out_status
);

  // an overrun beat carries no components and never ends the line
  `PSRD_ASSERT_NOW(a_err_beat, out_valid && out_status, out_write_mask == 4'h0 && !out_line_done && out_red == 8'd0 && out_alpha == 8'd0)

  // a good beat covers at least one pixel and writes something
  `PSRD_ASSERT_NOW(a_run_nonzero, out_valid && !out_status, out_run_length != 16'd0 && out_write_mask != 4'h0)

  // components outside the write mask read as zero
  `PSRD_ASSERT_NOW(a_comp_masked, out_valid, (out_write_mask[3] || out_red == 8'd0) && (out_write_mask[2] || out_green == 8'd0) && (out_write_mask[1] || out_blue == 8'd0) && (out_write_mask[0] || out_alpha == 8'd0))

  // a stalled result beat holds
  `PSRD_ASSERT_NEXT(a_hold, out_valid && out_stall, out_valid && $stable(out_start_x) && $stable(out_run_length) && $stable(out_write_mask) && $stable(out_channel_index) && $stable(out_status))

endmodule

bind pic_scanline_rle_decoder psrd_checker u_psrd_checker (.*);
